>>> design/glt_pkg.sv
// shared types and constants for the glyph locator text cursor
// no dependencies; compiled first
`timescale 1ns / 1ps
`default_nettype none

package glt_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int HEADER_BYTES    = 8;

    localparam logic [7:0] CODE_NEWLINE = 8'd10;
    localparam logic [7:0] GAP_LIMIT    = 8'd128;

    localparam int CFG_AW = 5;
    localparam int CFG_DW = 32;

    // configuration register indexes (paddr[4:2])
    localparam logic [2:0] REG_FONT_PRESENT = 3'd0;
    localparam logic [2:0] REG_GLYPH_HEIGHT = 3'd1;
    localparam logic [2:0] REG_LINE_GAP     = 3'd2;
    localparam logic [2:0] REG_CHAR_GAP     = 3'd3;
    localparam logic [2:0] REG_FIRST_CODE   = 3'd4;
    localparam logic [2:0] REG_GLYPH_COUNT  = 3'd5;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_CURSOR  = 2'd1,
        OP_WRITE   = 2'd2,
        OP_MEASURE = 2'd3
    } t_opcode;

    typedef enum logic {
        RK_GLYPH = 1'b0,
        RK_SUM   = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_EMIT_GLYPH,
        ST_MREAD,
        ST_MADD,
        ST_EMIT_SUM
    } t_state;

    typedef struct packed {
        t_opcode            opcode;
        logic        [7:0]  char_code;
        logic        [7:0]  table_index;
        logic        [7:0]  width_value;
        logic signed [15:0] new_x;
        logic signed [15:0] new_y;
        logic               last_char;
    } t_in_item;

    typedef struct packed {
        t_kind              result_kind;
        logic        [15:0] glyph_offset;
        logic        [7:0]  glyph_width;
        logic        [7:0]  glyph_rows;
        logic signed [15:0] draw_x;
        logic signed [15:0] draw_y;
        logic        [15:0] string_width;
    } t_out_item;

endpackage

`default_nettype wire

>>> design/glt_if.sv
// valid/ready channel interfaces for input items and result items
// depends on glt_pkg
`timescale 1ns / 1ps
`default_nettype none

interface glt_in_if;
    import glt_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface glt_out_if;
    import glt_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> design/glyph_locator_text_cursor.sv
// character generator for a proportional bitmap font: width table, text cursor,
// glyph bitmap offset and string measurement
// depends on glt_pkg, glt_if (glt_in_if, glt_out_if) and glt_ram
//
//   channel   dir   handshake                          carries
//   i_in      in    valid/ready                        load, cursor, write, measure items
//   o_out     out   valid/ready                        glyph descriptor or string total
//   apb       in    psel/penable/pwrite, pready = 1    six font configuration registers
//
// load, set cursor, newline and out-of-font writes are completed in the idle state
// a glyph write walks the width table, entries 0..index, through the ram's single read port
// a measure of a code in the font goes through a ram read and an add, other codes are summed in idle;
// a measure marked last then passes through the emit state for the total
// reset is synchronous, active low; the width table is not cleared
// results sit in an output register; a new item is taken while a result waits, and the
// block holds in its emit state only while that register is still full
`timescale 1ns / 1ps
`default_nettype none

module glyph_locator_text_cursor #(
    parameter int TABLE_DEPTH = glt_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    glt_in_if.sink                           i_in,
    glt_out_if.source                        o_out,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [glt_pkg::CFG_AW-1:0]  paddr,
    input  wire logic [glt_pkg::CFG_DW-1:0]  pwdata,
    output logic      [glt_pkg::CFG_DW-1:0]  prdata,
    output logic                             pready
);

    import glt_pkg::*;

    localparam int         AW        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [8:0] DEPTH_LIM = 9'(TABLE_DEPTH);

    // configuration
    logic        r_font_present;
    logic [7:0]  r_glyph_height;
    logic [7:0]  r_line_gap;
    logic [7:0]  r_char_gap;
    logic [7:0]  r_first_code;
    logic [7:0]  r_glyph_count;
    logic        cfg_we;

    // control and state
    t_state             r_state, n_state;
    logic signed [15:0] r_col, n_col;
    logic signed [15:0] r_row, n_row;
    logic        [15:0] r_sum, n_sum;
    logic               r_pend, n_pend;
    logic               r_issue_done, n_issue_done;
    logic               r_out_valid, n_out_valid;

    // datapath
    logic [7:0]  r_idx, n_idx;
    logic [7:0]  r_addr, n_addr;
    logic        r_pend_last, n_pend_last;
    logic        r_pend_oob, n_pend_oob;
    logic [15:0] r_offset, n_offset;
    logic [7:0]  r_w, n_w;
    logic [7:0]  r_code, n_code;
    logic        r_last, n_last;
    t_out_item   r_out, n_out;

    // ram port
    logic          ram_we;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    t_in_item    in_item;
    logic        in_ready;
    logic        in_font;
    logic        idx_ok;
    logic        can_load;
    logic [8:0]  font_end;
    logic [8:0]  h_round;
    logic [5:0]  rows;
    logic [7:0]  rd_val;
    logic [13:0] prod;

    glt_ram #(
        .WIDTH (8),
        .DEPTH (TABLE_DEPTH)
    ) u_width_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (in_item.table_index[AW-1:0]),
        .i_wdata (in_item.width_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // configuration port
    assign cfg_we = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_font_present <= 1'b0;
            r_glyph_height <= '0;
            r_line_gap     <= '0;
            r_char_gap     <= '0;
            r_first_code   <= '0;
            r_glyph_count  <= '0;
        end else if (cfg_we) begin
            unique case (paddr[4:2])
                REG_FONT_PRESENT: r_font_present <= pwdata[0];
                REG_GLYPH_HEIGHT: r_glyph_height <= pwdata[7:0];
                REG_LINE_GAP:     r_line_gap     <= pwdata[7:0];
                REG_CHAR_GAP:     r_char_gap     <= pwdata[7:0];
                REG_FIRST_CODE:   r_first_code   <= pwdata[7:0];
                REG_GLYPH_COUNT:  r_glyph_count  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_FONT_PRESENT: prdata = {31'b0, r_font_present};
            REG_GLYPH_HEIGHT: prdata = {24'b0, r_glyph_height};
            REG_LINE_GAP:     prdata = {24'b0, r_line_gap};
            REG_CHAR_GAP:     prdata = {24'b0, r_char_gap};
            REG_FIRST_CODE:   prdata = {24'b0, r_first_code};
            REG_GLYPH_COUNT:  prdata = {24'b0, r_glyph_count};
            default:          prdata = '0;
        endcase
    end

    // decode helpers
    assign in_item  = i_in.payload;
    assign font_end = {1'b0, r_first_code} + {1'b0, r_glyph_count};
    assign in_font  = (in_item.char_code >= r_first_code) &&
                      ({1'b0, in_item.char_code} < font_end);
    assign idx_ok   = {1'b0, in_item.table_index} < DEPTH_LIM;
    assign h_round  = {1'b0, r_glyph_height} + 9'd7;
    assign rows     = h_round[8:3];
    // entries past the table depth read as zero
    assign rd_val   = r_pend_oob ? 8'd0 : ram_rdata;
    assign prod     = {6'b0, rd_val} * {8'b0, rows};
    assign can_load = !r_out_valid || o_out.ready;

    always_comb begin
        n_state      = r_state;
        n_col        = r_col;
        n_row        = r_row;
        n_sum        = r_sum;
        n_pend       = 1'b0;
        n_issue_done = r_issue_done;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_idx        = r_idx;
        n_addr       = r_addr;
        n_pend_last  = r_pend_last;
        n_pend_oob   = r_pend_oob;
        n_offset     = r_offset;
        n_w          = r_w;
        n_code       = r_code;
        n_last       = r_last;
        n_out        = r_out;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_raddr    = r_addr[AW-1:0];
        in_ready     = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (i_in.valid) begin
                    case (in_item.opcode)
                        OP_LOAD: begin
                            ram_we = idx_ok;
                        end
                        OP_CURSOR: begin
                            n_col = in_item.new_x;
                            n_row = in_item.new_y;
                        end
                        OP_WRITE: begin
                            if (r_font_present) begin
                                if (in_item.char_code == CODE_NEWLINE) begin
                                    n_col = '0;
                                    n_row = r_row + 16'(r_glyph_height) + 16'(r_line_gap);
                                end else if (in_font) begin
                                    n_idx        = in_item.char_code - r_first_code;
                                    n_addr       = '0;
                                    n_issue_done = 1'b0;
                                    n_offset     = 16'(r_glyph_count) + 16'(HEADER_BYTES);
                                    n_code       = in_item.char_code;
                                    n_state      = ST_WALK;
                                end
                            end
                        end
                        OP_MEASURE: begin
                            n_last = in_item.last_char;
                            if (r_font_present && in_font) begin
                                n_idx   = in_item.char_code - r_first_code;
                                n_state = ST_MREAD;
                            end else begin
                                if (r_font_present) begin
                                    n_sum = r_sum + 16'(r_char_gap);
                                end
                                if (in_item.last_char) begin
                                    n_state = ST_EMIT_SUM;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_WALK: begin
                // one read issued per cycle, entries 0..idx; the last one is the glyph width
                if (!r_issue_done) begin
                    ram_re      = 1'b1;
                    ram_raddr   = r_addr[AW-1:0];
                    n_pend      = 1'b1;
                    n_pend_last = (r_addr == r_idx);
                    n_pend_oob  = {1'b0, r_addr} >= DEPTH_LIM;
                    n_addr      = r_addr + 8'd1;
                    if (r_addr == r_idx) begin
                        n_issue_done = 1'b1;
                    end
                end
                if (r_pend) begin
                    if (r_pend_last) begin
                        n_w     = rd_val;
                        n_state = ST_EMIT_GLYPH;
                    end else begin
                        n_offset = r_offset + {2'b0, prod};
                    end
                end
            end
            ST_EMIT_GLYPH: begin
                if (can_load) begin
                    n_out_valid        = 1'b1;
                    n_out.result_kind  = RK_GLYPH;
                    n_out.glyph_offset = r_offset;
                    n_out.glyph_width  = r_w;
                    n_out.glyph_rows   = r_glyph_height;
                    n_out.draw_x       = r_col;
                    n_out.draw_y       = r_row;
                    n_out.string_width = '0;
                    n_col = r_col + 16'(r_w) +
                            ((r_code < GAP_LIMIT) ? 16'(r_char_gap) : 16'd0);
                    n_state = ST_IDLE;
                end
            end
            ST_MREAD: begin
                ram_re     = 1'b1;
                ram_raddr  = r_idx[AW-1:0];
                n_pend     = 1'b1;
                n_pend_oob = {1'b0, r_idx} >= DEPTH_LIM;
                n_state    = ST_MADD;
            end
            ST_MADD: begin
                n_sum   = r_sum + 16'(r_char_gap) + 16'(rd_val);
                n_state = r_last ? ST_EMIT_SUM : ST_IDLE;
            end
            ST_EMIT_SUM: begin
                if (can_load) begin
                    n_out_valid        = 1'b1;
                    n_out.result_kind  = RK_SUM;
                    n_out.glyph_offset = '0;
                    n_out.glyph_width  = '0;
                    n_out.glyph_rows   = '0;
                    n_out.draw_x       = '0;
                    n_out.draw_y       = '0;
                    n_out.string_width = r_sum;
                    n_sum   = '0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_col        <= '0;
            r_row        <= '0;
            r_sum        <= '0;
            r_pend       <= 1'b0;
            r_issue_done <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_col        <= n_col;
            r_row        <= n_row;
            r_sum        <= n_sum;
            r_pend       <= n_pend;
            r_issue_done <= n_issue_done;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_addr      <= n_addr;
        r_pend_last <= n_pend_last;
        r_pend_oob  <= n_pend_oob;
        r_offset    <= n_offset;
        r_w         <= n_w;
        r_code      <= n_code;
        r_last      <= n_last;
        r_out       <= n_out;
    end

    assign i_in.ready    = in_ready;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    a_sum_fields_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.payload.result_kind == RK_SUM) |->
        (o_out.payload.glyph_offset == '0 && o_out.payload.draw_x == '0 &&
         o_out.payload.draw_y == '0 && o_out.payload.glyph_width == '0))
        else $error("string total carries glyph fields");

    a_sum_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT_SUM && can_load) |=> (r_sum == '0 && r_out_valid))
        else $error("measure sum not cleared after total");

    a_read_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == ST_WALK || r_state == ST_MADD))
        else $error("ram read data arrives outside walk or measure");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK && !r_issue_done) |-> (r_addr <= r_idx))
        else $error("width walk ran past the glyph index");

endmodule

`default_nettype wire

>>> design/glt_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module glt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> test/glyph_locator_text_cursor_tb.sv
// self-checking bench for glyph_locator_text_cursor: glyph descriptors and string totals
// are predicted by a cursor tracker class and checked transfer by transfer
// depends on glt_pkg, glt_if and the design under design/
`timescale 1ns / 1ps

import glt_pkg::*;

class font_cursor_tracker;
    logic [7:0]  widths [TABLE_DEPTH_DEF];
    logic        font_on;
    logic [7:0]  height;
    logic [7:0]  line_gap;
    logic [7:0]  char_gap;
    logic [7:0]  first_code;
    logic [7:0]  glyph_count;
    logic [15:0] col;
    logic [15:0] row;
    logic [15:0] sum;
    t_out_item   awaited[$];
    int          errors;

    function new();
        foreach (widths[i]) widths[i] = '0;
        {font_on, height, line_gap, char_gap, first_code, glyph_count} = '0;
        {col, row, sum} = '0;
        errors = 0;
    endfunction

    function void report(string msg);
        errors++;
        if (errors <= 10) $display("error: %s", msg);
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
        case (idx)
            REG_FONT_PRESENT: font_on     = v[0];
            REG_GLYPH_HEIGHT: height      = v[7:0];
            REG_LINE_GAP:     line_gap    = v[7:0];
            REG_CHAR_GAP:     char_gap    = v[7:0];
            REG_FIRST_CODE:   first_code  = v[7:0];
            REG_GLYPH_COUNT:  glyph_count = v[7:0];
            default: ;
        endcase
    endfunction

    function logic [7:0] read_width(int i);
        return (i < TABLE_DEPTH_DEF) ? widths[i] : 8'd0;
    endfunction

    function bit in_font(logic [7:0] c);
        return int'(c) >= int'(first_code) && int'(c) < int'(first_code) + int'(glyph_count);
    endfunction

    // advance the cursor and width table by one item, queue the result it causes
    function void accept_item(t_in_item it);
        t_out_item   r;
        int          idx;
        int          rows;
        logic [15:0] offs;
        logic [7:0]  w;
        r = '0;
        case (it.opcode)
            OP_LOAD: begin
                if (int'(it.table_index) < TABLE_DEPTH_DEF) widths[it.table_index] = it.width_value;
            end
            OP_CURSOR: begin
                col = it.new_x;
                row = it.new_y;
            end
            OP_WRITE: begin
                if (font_on) begin
                    if (it.char_code == CODE_NEWLINE) begin
                        col = '0;
                        row = row + height + line_gap;
                    end else if (in_font(it.char_code)) begin
                        idx  = int'(it.char_code) - int'(first_code);
                        rows = (int'(height) + 7) / 8;
                        offs = 16'(int'(glyph_count) + HEADER_BYTES);
                        for (int i = 0; i < idx; i++) offs = offs + 16'(int'(read_width(i)) * rows);
                        w = read_width(idx);
                        r.result_kind  = RK_GLYPH;
                        r.glyph_offset = offs;
                        r.glyph_width  = w;
                        r.glyph_rows   = height;
                        r.draw_x       = col;
                        r.draw_y       = row;
                        awaited.push_back(r);
                        col = col + w;
                        if (it.char_code < GAP_LIMIT) col = col + char_gap;
                    end
                end
            end
            OP_MEASURE: begin
                if (font_on) begin
                    sum = sum + char_gap;
                    if (in_font(it.char_code))
                        sum = sum + read_width(int'(it.char_code) - int'(first_code));
                end
                if (it.last_char) begin
                    r.result_kind  = RK_SUM;
                    r.string_width = sum;
                    awaited.push_back(r);
                    sum = '0;
                end
            end
            default: ;
        endcase
    endfunction

    function void cmp(string name, logic signed [31:0] want, logic signed [31:0] got);
        if (got !== want) report($sformatf("%s expected %0d, got %0d", name, want, got));
    endfunction

    function void match_result(t_out_item got);
        t_out_item want;
        if (awaited.size() == 0) begin
            report($sformatf("result with nothing expected: kind %0d offset %0d total %0d",
                             got.result_kind, got.glyph_offset, got.string_width));
            return;
        end
        want = awaited.pop_front();
        cmp("result_kind", want.result_kind, got.result_kind);
        cmp("glyph_offset", want.glyph_offset, got.glyph_offset);
        cmp("glyph_width", want.glyph_width, got.glyph_width);
        cmp("glyph_rows", want.glyph_rows, got.glyph_rows);
        cmp("draw_x", want.draw_x, got.draw_x);
        cmp("draw_y", want.draw_y, got.draw_y);
        cmp("string_width", want.string_width, got.string_width);
    endfunction

    function void close_out();
        while (awaited.size() != 0) begin
            report($sformatf("result never arrived: kind %0d", awaited[0].result_kind));
            void'(awaited.pop_front());
        end
    endfunction
endclass

module glyph_locator_text_cursor_tb;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [CFG_AW-1:0]   paddr;
    logic [CFG_DW-1:0]   pwdata;
    logic [CFG_DW-1:0]   prdata;
    logic                pready;
    bit                  in_steady;
    bit                  out_steady;

    glt_in_if  in_ch ();
    glt_out_if out_ch ();

    font_cursor_tracker tracker = new();

    glyph_locator_text_cursor dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_in_item noise_item();
        t_in_item it;
        it.opcode      = OP_LOAD;
        it.char_code   = 8'($urandom);
        it.table_index = 8'($urandom);
        it.width_value = 8'($urandom);
        it.new_x       = 16'($urandom);
        it.new_y       = 16'($urandom);
        it.last_char   = 1'($urandom);
        return it;
    endfunction

    function automatic t_in_item load_item(int idx, int w);
        t_in_item it;
        it             = noise_item();
        it.opcode      = OP_LOAD;
        it.table_index = 8'(idx);
        it.width_value = 8'(w);
        return it;
    endfunction

    function automatic t_in_item cursor_item(int x, int y);
        t_in_item it;
        it        = noise_item();
        it.opcode = OP_CURSOR;
        it.new_x  = 16'(x);
        it.new_y  = 16'(y);
        return it;
    endfunction

    function automatic t_in_item char_item(t_opcode op, int code, bit last);
        t_in_item it;
        it           = noise_item();
        it.opcode    = op;
        it.char_code = 8'(code);
        it.last_char = last;
        return it;
    endfunction

    // mostly codes inside the loaded font, some newlines and stray codes
    function automatic int font_code();
        int r;
        int lo;
        int hi;
        r  = $urandom_range(99, 0);
        lo = tracker.first_code;
        hi = lo + tracker.glyph_count - 1;
        if (hi > 255) hi = 255;
        if (r < 75 && tracker.glyph_count != 0) return $urandom_range(hi, lo);
        if (r < 85) return CODE_NEWLINE;
        return $urandom_range(255, 0);
    endfunction

    function automatic t_in_item rand_item();
        int pick;
        pick = $urandom_range(99, 0);
        if (pick < 12) return load_item($urandom_range(255, 0), $urandom_range(255, 0));
        if (pick < 20) return cursor_item($urandom_range(65535, 0), $urandom_range(65535, 0));
        if (pick < 58) return char_item(OP_WRITE, font_code(), 1'($urandom));
        return char_item(OP_MEASURE, font_code(), $urandom_range(3, 0) == 0);
    endfunction

    task automatic send_item(input t_in_item it);
        int gap;
        if ($urandom_range(29, 0) == 0) in_steady = !in_steady;
        gap = in_steady ? 0 : $urandom_range(6, 0);
        @(negedge i_clk);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        tracker.accept_item(it);
    endtask

    task automatic run_random(int n);
        for (int i = 0; i < n; i++) send_item(rand_item());
    endtask

    // drain all results, then cover the longest table walk of a silent item
    task automatic wait_idle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (tracker.awaited.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    // apb write followed by a read back of the same register
    task automatic program_reg(logic [2:0] idx, logic [31:0] v);
        logic [31:0] rd;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        tracker.set_reg(idx, v);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== v) tracker.report($sformatf("register %0d read %0h, wrote %0h", idx, rd, v));
    endtask

    task automatic set_font(bit fp, int h, int lg, int cg, int fc, int gc);
        wait_idle();
        program_reg(REG_FONT_PRESENT, 32'(fp));
        program_reg(REG_GLYPH_HEIGHT, 32'(h));
        program_reg(REG_LINE_GAP, 32'(lg));
        program_reg(REG_CHAR_GAP, 32'(cg));
        program_reg(REG_FIRST_CODE, 32'(fc));
        program_reg(REG_GLYPH_COUNT, 32'(gc));
    endtask

    // result side: random stall before each transfer, with stall-free stretches
    initial begin
        int stall;
        out_ch.ready = 1'b0;
        forever begin
            if ($urandom_range(29, 0) == 0) out_steady = !out_steady;
            stall = out_steady ? 0 : $urandom_range(6, 0);
            @(negedge i_clk);
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            tracker.match_result(out_ch.payload);
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // every width entry gets a value before any glyph can read it
        for (int i = 0; i < TABLE_DEPTH_DEF; i++)
            send_item(load_item(i, (i == 0) ? 0 : (i == 255) ? 255 : $urandom_range(255, 0)));

        // no font loaded: write is dropped, total comes back as zero
        send_item(char_item(OP_WRITE, 65, 1'b0));
        send_item(char_item(OP_MEASURE, 65, 1'b1));

        set_font(1'b1, 8, 2, 1, 32, 96);
        send_item(cursor_item(32767, -32768));
        send_item(char_item(OP_WRITE, 32, 1'b0));
        send_item(char_item(OP_WRITE, 127, 1'b0));
        send_item(char_item(OP_WRITE, CODE_NEWLINE, 1'b0));
        send_item(char_item(OP_WRITE, 31, 1'b0));
        send_item(char_item(OP_WRITE, 128, 1'b0));
        send_item(char_item(OP_MEASURE, 65, 1'b0));
        send_item(char_item(OP_MEASURE, CODE_NEWLINE, 1'b0));
        send_item(char_item(OP_MEASURE, 255, 1'b1));
        send_item(char_item(OP_MEASURE, 40, 1'b1));
        send_item(load_item(0, 255));
        send_item(char_item(OP_WRITE, 33, 1'b0));

        // widest settings: longest table walk, codes of 128 and above without the gap
        set_font(1'b1, 255, 255, 255, 0, 255);
        send_item(cursor_item(-1, 32767));
        send_item(char_item(OP_WRITE, 254, 1'b0));
        send_item(char_item(OP_WRITE, 0, 1'b0));
        send_item(char_item(OP_WRITE, CODE_NEWLINE, 1'b0));
        send_item(char_item(OP_MEASURE, CODE_NEWLINE, 1'b0));
        send_item(char_item(OP_MEASURE, 200, 1'b1));
        send_item(load_item(255, 0));

        set_font(1'b1, 0, 0, 0, 200, 56);
        run_random(110);
        set_font(1'b1, 1, 0, 3, 0, 0);
        run_random(90);
        set_font(1'b0, $urandom_range(255, 0), $urandom_range(255, 0), $urandom_range(255, 0),
                 $urandom_range(160, 0), $urandom_range(255, 1));
        run_random(70);
        set_font(1'b1, 9, 1, 2, 255, 255);
        run_random(100);
        for (int p = 0; p < 3; p++) begin
            set_font(1'b1, $urandom_range(255, 0), $urandom_range(255, 0), $urandom_range(255, 0),
                     $urandom_range(160, 0), $urandom_range(255, 1));
            run_random(100);
        end

        wait_idle();
        tracker.close_out();
        if (tracker.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #15_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> sim.f
design/glt_pkg.sv
design/glt_if.sv
design/glt_ram.sv
design/glyph_locator_text_cursor.sv
test/glyph_locator_text_cursor_tb.sv
